@@ rtl/slex_pkg.sv @@
// shared types, token codes and keyword lookup for the lexer
package slex_pkg;

    // default longest word that is checked against the keyword list
    localparam int KW_MAX_LEN_DEF = 8;
    // result queue depth between scanner and emitter
    localparam int QUEUE_DEPTH = 4;

    // token codes
    localparam logic [5:0] T_ID     = 6'd0;
    localparam logic [5:0] T_NUM    = 6'd1;
    localparam logic [5:0] T_STR    = 6'd2;
    localparam logic [5:0] T_KW0    = 6'd3;
    localparam logic [5:0] T_ASSIGN = 6'd26;
    localparam logic [5:0] T_EQ     = 6'd27;
    localparam logic [5:0] T_NEQ    = 6'd28;
    localparam logic [5:0] T_LT     = 6'd29;
    localparam logic [5:0] T_LE     = 6'd30;
    localparam logic [5:0] T_GT     = 6'd31;
    localparam logic [5:0] T_GE     = 6'd32;
    localparam logic [5:0] T_ADD    = 6'd33;
    localparam logic [5:0] T_SUB    = 6'd34;
    localparam logic [5:0] T_MUL    = 6'd35;
    localparam logic [5:0] T_DIV    = 6'd36;
    localparam logic [5:0] T_POW    = 6'd37;
    localparam logic [5:0] T_CAT    = 6'd38;
    localparam logic [5:0] T_SEMI   = 6'd39;
    localparam logic [5:0] T_LPAR   = 6'd40;
    localparam logic [5:0] T_RPAR   = 6'd41;
    localparam logic [5:0] T_COMMA  = 6'd42;
    localparam logic [5:0] T_ERR    = 6'd43;
    localparam logic [5:0] T_EOF    = 6'd44;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_TOKEN = 1'b1;

    // one result
    typedef struct packed {
        logic       kind;
        logic [5:0] code;
        logic [7:0] lex_byte;
    } res_t;

    // results caused by one input transaction (one or two)
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    // keyword text, right-aligned, first character in the highest used byte
    function automatic logic [63:0] kw_text(input int i);
        logic [63:0] t;
        begin
            case (i)
                0:  t = 64'("if");
                1:  t = 64'("then");
                2:  t = 64'("else");
                3:  t = 64'("true");
                4:  t = 64'("false");
                5:  t = 64'("nil");
                6:  t = 64'("while");
                7:  t = 64'("do");
                8:  t = 64'("end");
                9:  t = 64'("function");
                10: t = 64'("local");
                11: t = 64'("return");
                12: t = 64'("read");
                13: t = 64'("write");
                14: t = 64'("and");
                15: t = 64'("or");
                16: t = 64'("not");
                17: t = 64'("break");
                18: t = 64'("elseif");
                19: t = 64'("for");
                20: t = 64'("in");
                21: t = 64'("repeat");
                22: t = 64'("until");
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    function automatic logic [3:0] kw_len(input int i);
        logic [3:0] n;
        begin
            case (i)
                0, 7, 15, 20:             n = 4'd2;
                5, 8, 14, 16, 19:         n = 4'd3;
                1, 2, 3, 12:              n = 4'd4;
                4, 6, 10, 13, 17, 22:     n = 4'd5;
                11, 18, 21:               n = 4'd6;
                9:                        n = 4'd8;
                default:                  n = 4'd0;
            endcase
            return n;
        end
    endfunction

    // w holds word byte k at bits [8k+7:8k]; n is the word length (at most 8)
    function automatic logic [5:0] kw_lookup(input logic [63:0] w, input logic [3:0] n);
        logic [5:0]  code;
        logic [63:0] t;
        logic [3:0]  len;
        logic        hit;
        begin
            code = T_ID;
            for (int i = 0; i < 23; i++) begin
                t   = kw_text(i);
                len = kw_len(i);
                hit = (len == n);
                for (int k = 0; k < 8; k++) begin
                    if (k < int'(len) && w[8*k +: 8] != t[8*(int'(len)-1-k) +: 8])
                        hit = 1'b0;
                end
                if (hit)
                    code = T_KW0 + 6'(i);
            end
            return code;
        end
    endfunction

endpackage

@@ rtl/slex_scan.sv @@
// front end: scanner state machine, one source byte per transaction
module slex_scan
    import slex_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,        // input transaction accepted this cycle
    input  logic [7:0] char_code,
    input  logic       end_of_input,
    output logic       push,        // results to queue this cycle
    output entry_t     entry
);

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int IW = $clog2(KEYWORD_MAX_LEN);

    // scan state codes
    localparam logic [4:0] S_START   = 5'd0;
    localparam logic [4:0] S_MINUS   = 5'd1;
    localparam logic [4:0] S_COMMENT = 5'd2;
    localparam logic [4:0] S_RIM     = 5'd3;
    localparam logic [4:0] S_BLOCK   = 5'd4;
    localparam logic [4:0] S_RIMEND  = 5'd5;
    localparam logic [4:0] S_IDENT   = 5'd6;
    localparam logic [4:0] S_NUMBER  = 5'd7;
    localparam logic [4:0] S_EQUAL   = 5'd8;
    localparam logic [4:0] S_DOTNUM  = 5'd9;
    localparam logic [4:0] S_DECIMAL = 5'd10;
    localparam logic [4:0] S_DOT     = 5'd11;
    localparam logic [4:0] S_TILDE   = 5'd12;
    localparam logic [4:0] S_LESS    = 5'd13;
    localparam logic [4:0] S_GREATER = 5'd14;
    localparam logic [4:0] S_STR     = 5'd15;
    localparam logic [4:0] S_EXPNUM  = 5'd16;
    localparam logic [4:0] S_LINE    = 5'd17;
    localparam logic [4:0] S_EXP     = 5'd18;
    localparam logic [4:0] S_EXPSIGN = 5'd19;
    localparam logic [4:0] S_ESC     = 5'd20;
    localparam logic [4:0] S_ESC2    = 5'd21;
    localparam logic [4:0] S_ESC3    = 5'd22;

    logic [4:0]    state_reg, state_next;
    logic [LW-1:0] wlen_reg, wlen_next;
    logic [9:0]    esc_reg, esc_next;
    logic [7:0]    wbuf_reg [KEYWORD_MAX_LEN];

    logic [7:0]  c;
    logic        eof, dig, alpha, space, wchar, is_e;
    logic [3:0]  dval;
    logic [9:0]  esc_sum;

    // start-state decode of the current byte
    logic [4:0]  st_state;
    logic        st_v;
    res_t        st_res;
    logic        st_ident;

    logic        wb_we;
    logic [7:0]  wb_data;
    logic        wb_first;
    logic [63:0] word;
    logic [5:0]  word_code;
    logic [1:0]  cnt;
    res_t        r0, r1;

    assign c     = char_code;
    assign eof   = end_of_input;
    assign dig   = !eof && (c >= "0") && (c <= "9");
    assign alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    assign wchar = !eof && (alpha || ((c >= "0") && (c <= "9")) || (c == "_"));
    assign is_e  = !eof && ((c == "e") || (c == "E"));
    assign dval  = 4'(c - "0");
    assign esc_sum = (esc_reg << 3) + (esc_reg << 1) + 10'(dval);

    // identifier classification
    always_comb
    begin
        for (int k = 0; k < 8; k++)
            word[8*k +: 8] = wbuf_reg[k];
        if (wlen_reg <= LW'(8))
            word_code = kw_lookup(word, 4'(wlen_reg));
        else
            word_code = T_ID;
    end

    // what the start state makes of this byte
    always_comb
    begin
        st_state = S_START;
        st_v     = 1'b0;
        st_res   = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
        st_ident = 1'b0;
        if (eof) begin
            st_v = 1'b1;
            st_res.code = T_EOF;
        end else if (space) begin
            st_v = 1'b0;
        end else if (alpha || c == "_") begin
            st_v = 1'b1;
            st_res = '{kind: KIND_BYTE, code: 6'd0, lex_byte: c};
            st_state = S_IDENT;
            st_ident = 1'b1;
        end else if ((c >= "0") && (c <= "9")) begin
            st_v = 1'b1;
            st_res = '{kind: KIND_BYTE, code: 6'd0, lex_byte: c};
            st_state = S_NUMBER;
        end else begin
            case (c)
                ";": begin st_v = 1'b1; st_res.code = T_SEMI;  end
                "+": begin st_v = 1'b1; st_res.code = T_ADD;   end
                "*": begin st_v = 1'b1; st_res.code = T_MUL;   end
                "/": begin st_v = 1'b1; st_res.code = T_DIV;   end
                "^": begin st_v = 1'b1; st_res.code = T_POW;   end
                "(": begin st_v = 1'b1; st_res.code = T_LPAR;  end
                ")": begin st_v = 1'b1; st_res.code = T_RPAR;  end
                ",": begin st_v = 1'b1; st_res.code = T_COMMA; end
                "-": st_state = S_MINUS;
                "=": st_state = S_EQUAL;
                ".": st_state = S_DOT;
                "~": st_state = S_TILDE;
                "<": st_state = S_LESS;
                ">": st_state = S_GREATER;
                "\"": st_state = S_STR;
                default: begin st_v = 1'b1; st_res.code = T_ERR; end
            endcase
        end
    end

    // main transition
    always_comb
    begin
        state_next = state_reg;
        wlen_next  = wlen_reg;
        esc_next   = esc_reg;
        wb_we      = 1'b0;
        wb_data    = c;
        wb_first   = 1'b0;
        cnt        = 2'd0;
        r0         = '{kind: KIND_BYTE, code: 6'd0, lex_byte: c};
        r1         = st_res;

        case (state_reg)
            S_START:
            begin
                state_next = st_state;
                cnt        = {1'b0, st_v};
                r0         = st_res;
                wb_first   = st_ident;
            end
            S_IDENT:
            begin
                if (wchar) begin
                    wb_we = (wlen_reg < LW'(KEYWORD_MAX_LEN));
                    if (wlen_reg <= LW'(KEYWORD_MAX_LEN))
                        wlen_next = wlen_reg + LW'(1);
                    cnt = 2'd1;
                end else begin
                    r0 = '{kind: KIND_TOKEN, code: word_code, lex_byte: 8'd0};
                    cnt = st_v ? 2'd2 : 2'd1;
                    state_next = st_state;
                    wb_first = st_ident;
                end
            end
            S_MINUS, S_EQUAL, S_DOT, S_TILDE, S_LESS, S_GREATER:
            begin
                r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                if (!eof && c == "-" && state_reg == S_MINUS) begin
                    state_next = S_COMMENT;
                end else if (!eof && c == "." && state_reg == S_DOT) begin
                    r0.code = T_CAT; cnt = 2'd1; state_next = S_START;
                end else if (!eof && c == "=" && state_reg != S_MINUS
                             && state_reg != S_DOT) begin
                    cnt = 2'd1;
                    state_next = S_START;
                    case (state_reg)
                        S_EQUAL: r0.code = T_EQ;
                        S_TILDE: r0.code = T_NEQ;
                        S_LESS:  r0.code = T_LE;
                        default: r0.code = T_GE;
                    endcase
                end else begin
                    case (state_reg)
                        S_MINUS:   r0.code = T_SUB;
                        S_EQUAL:   r0.code = T_ASSIGN;
                        S_LESS:    r0.code = T_LT;
                        S_GREATER: r0.code = T_GT;
                        default:   r0.code = T_ERR;
                    endcase
                    cnt = st_v ? 2'd2 : 2'd1;
                    state_next = st_state;
                    wb_first = st_ident;
                end
            end
            S_COMMENT, S_RIM, S_LINE:
            begin
                if (eof) begin
                    state_next = st_state;
                    cnt = {1'b0, st_v};
                    r0 = st_res;
                end else if (c == "\n") begin
                    state_next = S_START;
                end else if (c == "[" && state_reg == S_COMMENT) begin
                    state_next = S_RIM;
                end else if (c == "[" && state_reg == S_RIM) begin
                    state_next = S_BLOCK;
                end else begin
                    state_next = S_LINE;
                end
            end
            S_BLOCK, S_RIMEND:
            begin
                if (eof) begin
                    r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                    cnt = 2'd1;
                    state_next = S_START;
                end else if (c == "]") begin
                    state_next = (state_reg == S_RIMEND) ? S_START : S_RIMEND;
                end else begin
                    state_next = S_BLOCK;
                end
            end
            S_NUMBER, S_DECIMAL, S_EXPNUM:
            begin
                if (dig) begin
                    cnt = 2'd1;
                end else if (is_e && state_reg != S_EXPNUM) begin
                    cnt = 2'd1; state_next = S_EXP;
                end else if (!eof && c == "." && state_reg == S_NUMBER) begin
                    cnt = 2'd1; state_next = S_DOTNUM;
                end else begin
                    r0 = '{kind: KIND_TOKEN, code: T_NUM, lex_byte: 8'd0};
                    cnt = st_v ? 2'd2 : 2'd1;
                    state_next = st_state;
                    wb_first = st_ident;
                end
            end
            S_DOTNUM, S_EXP, S_EXPSIGN:
            begin
                cnt = 2'd1;
                if (dig) begin
                    state_next = (state_reg == S_DOTNUM) ? S_DECIMAL : S_EXPNUM;
                end else if (!eof && (c == "-" || c == "+") && state_reg == S_EXP) begin
                    state_next = S_EXPSIGN;
                end else begin
                    r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                    state_next = S_START;
                end
            end
            S_STR:
            begin
                if (eof) begin
                    r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                    cnt = 2'd1; state_next = S_START;
                end else if (c == "\"") begin
                    r0 = '{kind: KIND_TOKEN, code: T_STR, lex_byte: 8'd0};
                    cnt = 2'd1; state_next = S_START;
                end else if (c == "\\") begin
                    state_next = S_ESC;
                end else if (c >= 8'd32) begin
                    cnt = 2'd1;
                end
            end
            S_ESC:
            begin
                cnt = 2'd1;
                state_next = S_STR;
                if (eof) begin
                    r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                    state_next = S_START;
                end else if (c == "n") begin
                    r0.lex_byte = 8'd10;
                end else if (c == "t") begin
                    r0.lex_byte = 8'd9;
                end else if (c == "\\" || c == "\"") begin
                    r0.lex_byte = c;
                end else if (dig) begin
                    cnt = 2'd0;
                    esc_next = 10'(dval);
                    state_next = S_ESC2;
                end else begin
                    r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                    state_next = S_START;
                end
            end
            S_ESC2:
            begin
                if (dig) begin
                    esc_next = esc_sum;
                    state_next = S_ESC3;
                end else begin
                    r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                    cnt = 2'd1; state_next = S_START;
                end
            end
            S_ESC3:
            begin
                cnt = 2'd1;
                if (dig) begin
                    esc_next = esc_sum;
                    if (esc_sum == 10'd0 || esc_sum > 10'd255) begin
                        r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                        state_next = S_START;
                    end else begin
                        r0.lex_byte = esc_sum[7:0];
                        state_next = S_STR;
                    end
                end else begin
                    r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                    state_next = S_START;
                end
            end
            default:
            begin
                r0 = '{kind: KIND_TOKEN, code: T_ERR, lex_byte: 8'd0};
                cnt = 2'd1; state_next = S_START;
            end
        endcase

        if (wb_first)
            wlen_next = LW'(1);
    end

    assign push  = take && (cnt != 2'd0);
    assign entry = '{two: cnt[1], r0: r0, r1: r1};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_START;
            wlen_reg  <= '0;
            esc_reg   <= '0;
        end else if (take) begin
            state_reg <= state_next;
            wlen_reg  <= wlen_next;
            esc_reg   <= esc_next;
        end
    end

    // first bytes of the current word
    always_ff @(posedge clk)
    begin
        if (take && wb_first)
            wbuf_reg[0] <= c;
        else if (take && wb_we)
            wbuf_reg[wlen_reg[IW-1:0]] <= wb_data;
    end

endmodule

@@ rtl/slex_queue.sv @@
// short result queue between scanner and emitter
module slex_queue
    import slex_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    entry_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [PW:0]     count_reg;

    assign full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push)
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            if (pop)
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

endmodule

@@ rtl/slex_emit.sv @@
// back end: sends the one or two results of each queued entry
module slex_emit
    import slex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  entry_t      head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic sel_reg;
    res_t cur;

    assign cur      = sel_reg ? head.r1 : head.r0;
    assign m_tvalid = !empty;
    assign m_tdata  = {2'b00, cur.lex_byte, cur.code};
    assign m_tuser  = cur.kind;
    assign m_tlast  = sel_reg || !head.two;
    assign pop      = m_tvalid && m_tready && m_tlast;

    // second-result select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else if (m_tvalid && m_tready)
            sel_reg <= !m_tlast;
    end

endmodule

@@ rtl/script_language_lexer.sv @@
// top level of the streaming script language lexer
//
// Input stream: one source byte per transaction on s_tdata, s_tuser set
// marks end of input instead of a byte. Output stream: one result per
// transaction, m_tuser clear for a lexeme byte (in m_tdata[13:6]), set for
// a completed token (code in m_tdata[5:0]); m_tlast marks the last result
// of one input byte. A byte gives zero, one or two results.
// The scanner takes one byte per cycle while the queue is not full and
// writes its results into a four-entry queue in the same cycle; the first
// result shows on the output in the cycle after the byte is taken if the
// queue was empty. The emitter drains one result per cycle while m_tready
// is high, so the sustained rate is one byte per cycle while bytes give at
// most one result. When the receiver stalls the queue fills and s_tready
// drops once it is full; nothing is lost. Reset empties the queue and
// returns the scanner to its start state; no clearing pass is needed.
module script_language_lexer
    import slex_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic [0:0]  s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // token_code[5:0], lexeme_byte[13:6], zero fill
    output logic [0:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    logic   take, push, full, pop, empty;
    entry_t entry, head;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    slex_scan #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .char_code    (s_tdata),
        .end_of_input (s_tuser[0]),
        .push         (push),
        .entry        (entry)
    );

    slex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    slex_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
